[hw/rtl/aec_pkg.sv]
package aec_pkg;

  localparam int unsigned Q15       = 15;
  localparam logic [15:0] Q15_ONE   = 16'd32768;
  localparam logic [16:0] DECAY_Q15 = 17'd32735;
  localparam logic [15:0] PEAK_INIT = 16'd16384;

  localparam logic [2:0] REG_ENABLES  = 3'd0;
  localparam logic [2:0] REG_FADE     = 3'd1;
  localparam logic [2:0] REG_CLIP     = 3'd2;
  localparam logic [2:0] REG_REV_LEN  = 3'd3;
  localparam logic [2:0] REG_DLY_LEN  = 3'd4;
  localparam logic [2:0] REG_MIX      = 3'd5;
  localparam logic [2:0] REG_FEEDBACK = 3'd6;

  localparam int unsigned EN_REVERB = 0;
  localparam int unsigned EN_ECHO   = 1;
  localparam int unsigned EN_GAIN   = 2;
  localparam int unsigned EN_FADE   = 3;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV,
    OP_DIV_END,
    OP_SILENT,
    OP_REV_FB,
    OP_REV_WR,
    OP_REV_MIX,
    OP_REV_END,
    OP_ECHO,
    OP_GAIN_MUL,
    OP_GAIN_END,
    OP_FADE_L,
    OP_FADE_LR,
    OP_FADE_R,
    OP_BYPASS,
    OP_DECAY,
    OP_BLOCK,
    OP_OUT
  } op_e;

  typedef struct packed {
    logic [3:0]  effect_enables;
    logic [15:0] fade_gain;
    logic [4:0]  clip_gain;
    logic [15:0] reverb_length;
    logic [17:0] delay_length;
    logic [15:0] reverb_mix;
    logic [15:0] reverb_feedback;
  } cfg_t;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic       clear_done;
    logic       no_input;
    logic [3:0] enables;
  } status_t;

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    logic signed [23:0] r;
    if (v > 64'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -64'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] clamp_frac(input logic [15:0] f);
    return (f > Q15_ONE) ? Q15_ONE : f;
  endfunction

endpackage

[hw/rtl/aec_ram.sv]
module aec_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/aec_ctrl.sv]
module aec_ctrl #(
  parameter int unsigned DIV_STEPS = 31
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  aec_pkg::status_t status_i,
  output aec_pkg::cmd_t    cmd_o
);

  localparam int unsigned CW = $clog2(DIV_STEPS);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DIV      = 4'd1;
  localparam logic [3:0] S_DIV_END  = 4'd2;
  localparam logic [3:0] S_REV_FB   = 4'd3;
  localparam logic [3:0] S_REV_WR   = 4'd4;
  localparam logic [3:0] S_REV_MIX  = 4'd5;
  localparam logic [3:0] S_REV_END  = 4'd6;
  localparam logic [3:0] S_ECHO     = 4'd7;
  localparam logic [3:0] S_GAIN_MUL = 4'd8;
  localparam logic [3:0] S_GAIN_END = 4'd9;
  localparam logic [3:0] S_FADE_L   = 4'd10;
  localparam logic [3:0] S_FADE_LR  = 4'd11;
  localparam logic [3:0] S_FADE_R   = 4'd12;
  localparam logic [3:0] S_BYPASS   = 4'd13;
  localparam logic [3:0] S_DECAY    = 4'd14;
  localparam logic [3:0] S_BLOCK    = 4'd15;

  logic [3:0]    state_q, state_d;
  logic          out_q, out_d;
  logic          last_q, last_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [3:0]    en;
  logic [3:0]    after_div, after_rev, after_echo, after_gain;
  logic          in_acc;
  logic          out_free;

  assign en = status_i.enables;

  assign after_gain = en[aec_pkg::EN_FADE] ? S_FADE_L : S_BYPASS;
  assign after_echo = en[aec_pkg::EN_GAIN] ? S_GAIN_MUL : after_gain;
  assign after_rev  = en[aec_pkg::EN_ECHO] ? S_ECHO : after_echo;
  assign after_div  = en[aec_pkg::EN_REVERB] ? S_REV_FB : after_rev;

  assign in_stall_o = !((state_q == S_IDLE) && !last_q && status_i.clear_done);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    last_d    = last_q;
    out_d     = out_q;
    cmd_o.op  = aec_pkg::OP_NONE;
    if (out_q && !out_stall_i) begin
      out_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (last_q) begin
          if (out_free) begin
            cmd_o.op = aec_pkg::OP_OUT;
            out_d    = 1'b1;
            last_d   = 1'b0;
          end
        end else if (in_acc) begin
          cmd_o.op = aec_pkg::OP_LOAD;
          cnt_d    = '0;
          state_d  = S_DIV;
        end
      end
      S_DIV: begin
        if (status_i.no_input) begin
          cmd_o.op = aec_pkg::OP_SILENT;
          last_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          cmd_o.op = aec_pkg::OP_DIV;
          cnt_d    = cnt_q + CW'(1);
          if (cnt_q == CW'(DIV_STEPS - 1)) begin
            state_d = S_DIV_END;
          end
        end
      end
      S_DIV_END: begin
        cmd_o.op = aec_pkg::OP_DIV_END;
        state_d  = after_div;
      end
      S_REV_FB: begin
        cmd_o.op = aec_pkg::OP_REV_FB;
        state_d  = S_REV_WR;
      end
      S_REV_WR: begin
        cmd_o.op = aec_pkg::OP_REV_WR;
        state_d  = S_REV_MIX;
      end
      S_REV_MIX: begin
        cmd_o.op = aec_pkg::OP_REV_MIX;
        state_d  = S_REV_END;
      end
      S_REV_END: begin
        cmd_o.op = aec_pkg::OP_REV_END;
        state_d  = after_rev;
      end
      S_ECHO: begin
        cmd_o.op = aec_pkg::OP_ECHO;
        state_d  = after_echo;
      end
      S_GAIN_MUL: begin
        cmd_o.op = aec_pkg::OP_GAIN_MUL;
        state_d  = S_GAIN_END;
      end
      S_GAIN_END: begin
        cmd_o.op = aec_pkg::OP_GAIN_END;
        state_d  = after_gain;
      end
      S_FADE_L: begin
        cmd_o.op = aec_pkg::OP_FADE_L;
        state_d  = S_FADE_LR;
      end
      S_FADE_LR: begin
        cmd_o.op = aec_pkg::OP_FADE_LR;
        state_d  = S_FADE_R;
      end
      S_FADE_R: begin
        cmd_o.op = aec_pkg::OP_FADE_R;
        state_d  = S_DECAY;
      end
      S_BYPASS: begin
        cmd_o.op = aec_pkg::OP_BYPASS;
        state_d  = S_DECAY;
      end
      S_DECAY: begin
        cmd_o.op = aec_pkg::OP_DECAY;
        state_d  = S_BLOCK;
      end
      S_BLOCK: begin
        cmd_o.op = aec_pkg::OP_BLOCK;
        last_d   = 1'b1;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      last_q  <= 1'b0;
      out_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
      out_q   <= out_d;
    end
  end

  assign out_valid_o = out_q;

endmodule

[hw/rtl/aec_dp.sv]
module aec_dp #(
  parameter int unsigned REVERB_DEPTH = 65536,
  parameter int unsigned ECHO_DEPTH   = 262144,
  parameter int unsigned BLOCK_FRAMES = 1024,
  parameter int unsigned FRAC_BITS    = 15
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  aec_pkg::cfg_t                   cfg_i,
  input  aec_pkg::cmd_t                   cmd_i,
  output aec_pkg::status_t                status_o,
  input  logic signed [15:0]              sample_in_i,
  input  logic                            no_input_i,
  output logic signed [23:0]              left_out_o,
  output logic signed [23:0]              right_out_o,
  output logic                            rev_we_o,
  output logic [$clog2(REVERB_DEPTH)-1:0] rev_waddr_o,
  output logic [23:0]                     rev_wdata_o,
  output logic                            rev_re_o,
  output logic [$clog2(REVERB_DEPTH)-1:0] rev_raddr_o,
  input  logic [23:0]                     rev_rdata_i,
  output logic                            echo_we_o,
  output logic [$clog2(ECHO_DEPTH)-1:0]   echo_waddr_o,
  output logic [23:0]                     echo_wdata_o,
  output logic                            echo_re_o,
  output logic [$clog2(ECHO_DEPTH)-1:0]   echo_raddr_o,
  input  logic [23:0]                     echo_rdata_i
);

  localparam int unsigned NW   = 16 + FRAC_BITS;
  localparam int unsigned RAW  = $clog2(REVERB_DEPTH);
  localparam int unsigned EAW  = $clog2(ECHO_DEPTH);
  localparam int unsigned RLW  = ((RAW > 16) ? RAW : 16) + 1;
  localparam int unsigned ELW  = ((EAW > 18) ? EAW : 18) + 1;
  localparam int unsigned MAXD = (REVERB_DEPTH > ECHO_DEPTH) ? REVERB_DEPTH : ECHO_DEPTH;
  localparam int unsigned CLW  = $clog2(MAXD) + 1;
  localparam int unsigned BPW  = $clog2(BLOCK_FRAMES);

  logic signed [15:0] x_q;
  logic               no_in_q;
  logic               neg_q;
  logic [NW-1:0]      num_q, num_d;
  logic [15:0]        rem_q, rem_d;
  logic [16:0]        rem_sh;
  logic               qbit;
  logic [15:0]        mag;
  logic [15:0]        peak_q, peak_d, bmax_q, bmax_d, newp;
  logic [BPW-1:0]     bpos_q, bpos_d;
  logic signed [23:0] s_q, s_d, l_q, l_d, r_q, r_d, lo_q, ro_q;
  logic signed [41:0] prod_q, acc_q, acc_d;
  logic signed [41:0] mul_p;
  logic [16:0]        mul_au;
  logic signed [17:0] mul_a;
  logic signed [23:0] mul_b;
  logic signed [23:0] yr, ye;
  logic [15:0]        fb_c, mix_c, fade_c;
  logic [RAW-1:0]     rpos_q, rpos_d, rpos_nx;
  logic [EAW-1:0]     epos_q, epos_d, epos_nx;
  logic [RLW-1:0]     rlen_e, rpos_inc;
  logic [ELW-1:0]     elen_e, epos_inc;
  logic [CLW-1:0]     clr_q;
  logic               clr_done;
  logic signed [63:0] qs;
  logic signed [23:0] rev_wval;

  assign yr     = signed'(rev_rdata_i);
  assign ye     = signed'(echo_rdata_i);
  assign fb_c   = aec_pkg::clamp_frac(cfg_i.reverb_feedback);
  assign mix_c  = aec_pkg::clamp_frac(cfg_i.reverb_mix);
  assign fade_c = aec_pkg::clamp_frac(cfg_i.fade_gain);
  assign mag    = x_q[15] ? 16'(-x_q) : 16'(x_q);

  assign clr_done = (clr_q == CLW'(MAXD));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (!clr_done) begin
      clr_q <= clr_q + CLW'(1);
    end
  end

  always_comb begin
    rlen_e = (RLW'(cfg_i.reverb_length) > RLW'(REVERB_DEPTH)) ?
             RLW'(REVERB_DEPTH) : RLW'(cfg_i.reverb_length);
    if (rlen_e == '0) begin
      rlen_e = RLW'(1);
    end
    rpos_inc = RLW'(rpos_q) + RLW'(1);
    rpos_nx  = (rpos_inc >= rlen_e) ? '0 : rpos_inc[RAW-1:0];
    elen_e = (ELW'(cfg_i.delay_length) > ELW'(ECHO_DEPTH)) ?
             ELW'(ECHO_DEPTH) : ELW'(cfg_i.delay_length);
    if (elen_e == '0) begin
      elen_e = ELW'(1);
    end
    epos_inc = ELW'(epos_q) + ELW'(1);
    epos_nx  = (epos_inc >= elen_e) ? '0 : epos_inc[EAW-1:0];
  end

  assign rem_sh = {rem_q, num_q[NW-1]};
  assign qbit   = (rem_sh >= {1'b0, peak_q});
  assign qs     = neg_q ? -signed'(64'(num_q)) : signed'(64'(num_q));

  always_comb begin
    mul_au = '0;
    mul_b  = '0;
    unique case (cmd_i.op)
      aec_pkg::OP_REV_FB: begin
        mul_au = 17'(fb_c);
        mul_b  = yr;
      end
      aec_pkg::OP_REV_WR: begin
        mul_au = 17'(aec_pkg::Q15_ONE) - 17'(mix_c);
        mul_b  = s_q;
      end
      aec_pkg::OP_REV_MIX: begin
        mul_au = 17'(mix_c);
        mul_b  = yr;
      end
      aec_pkg::OP_GAIN_MUL: begin
        mul_au = 17'(cfg_i.clip_gain);
        mul_b  = s_q;
      end
      aec_pkg::OP_FADE_L: begin
        mul_au = 17'(fade_c);
        mul_b  = s_q;
      end
      aec_pkg::OP_FADE_LR: begin
        mul_au = 17'(aec_pkg::Q15_ONE) - 17'(fade_c);
        mul_b  = s_q;
      end
      aec_pkg::OP_DECAY: begin
        mul_au = aec_pkg::DECAY_Q15;
        mul_b  = signed'({8'b0, peak_q});
      end
      default: begin
      end
    endcase
  end

  assign mul_a = signed'({1'b0, mul_au});
  assign mul_p = mul_a * mul_b;

  assign rev_wval = aec_pkg::sat24(64'(s_q) + (64'(prod_q) >>> aec_pkg::Q15));

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    s_d    = s_q;
    l_d    = l_q;
    r_d    = r_q;
    acc_d  = acc_q;
    rpos_d = rpos_q;
    epos_d = epos_q;
    peak_d = peak_q;
    bmax_d = bmax_q;
    bpos_d = bpos_q;
    newp   = peak_q;
    unique case (cmd_i.op)
      aec_pkg::OP_DIV: begin
        rem_d = qbit ? 16'(rem_sh - {1'b0, peak_q}) : rem_sh[15:0];
        num_d = {num_q[NW-2:0], qbit};
      end
      aec_pkg::OP_DIV_END: begin
        s_d = aec_pkg::sat24(qs);
        if (!no_in_q && (mag > bmax_q)) begin
          bmax_d = mag;
        end
      end
      aec_pkg::OP_SILENT: begin
        l_d = '0;
        r_d = '0;
      end
      aec_pkg::OP_REV_MIX: begin
        acc_d = prod_q;
      end
      aec_pkg::OP_REV_END: begin
        if (fb_c != '0) begin
          s_d = aec_pkg::sat24((64'(acc_q) + 64'(prod_q)) >>> aec_pkg::Q15);
        end else begin
          s_d = aec_pkg::sat24(64'(s_q) + 64'(yr));
        end
        rpos_d = rpos_nx;
      end
      aec_pkg::OP_ECHO: begin
        s_d    = aec_pkg::sat24(64'(s_q) + 64'(ye));
        epos_d = epos_nx;
      end
      aec_pkg::OP_GAIN_END: begin
        s_d = aec_pkg::sat24(64'(prod_q));
      end
      aec_pkg::OP_FADE_LR: begin
        l_d = aec_pkg::sat24(64'(prod_q) >>> aec_pkg::Q15);
      end
      aec_pkg::OP_FADE_R: begin
        r_d = aec_pkg::sat24(64'(prod_q) >>> aec_pkg::Q15);
      end
      aec_pkg::OP_BYPASS: begin
        l_d = s_q;
        r_d = s_q;
      end
      aec_pkg::OP_BLOCK: begin
        if (bpos_q == BPW'(BLOCK_FRAMES - 1)) begin
          newp = (bmax_q > peak_q) ? bmax_q : prod_q[30:15];
          if (newp == '0) begin
            newp = 16'd1;
          end
          peak_d = newp;
          bmax_d = newp;
          bpos_d = '0;
        end else begin
          bpos_d = bpos_q + BPW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= aec_pkg::PEAK_INIT;
      bmax_q <= aec_pkg::PEAK_INIT;
      bpos_q <= '0;
      rpos_q <= '0;
      epos_q <= '0;
    end else begin
      peak_q <= peak_d;
      bmax_q <= bmax_d;
      bpos_q <= bpos_d;
      rpos_q <= rpos_d;
      epos_q <= epos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == aec_pkg::OP_LOAD) begin
      x_q     <= sample_in_i;
      no_in_q <= no_input_i;
      neg_q   <= sample_in_i[15];
      num_q   <= {(sample_in_i[15] ? 16'(-sample_in_i) : 16'(sample_in_i)),
                  FRAC_BITS'(0)};
      rem_q   <= '0;
    end else begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
    s_q    <= s_d;
    l_q    <= l_d;
    r_q    <= r_d;
    acc_q  <= acc_d;
    prod_q <= mul_p;
    if (cmd_i.op == aec_pkg::OP_OUT) begin
      lo_q <= l_q;
      ro_q <= r_q;
    end
  end

  assign rev_re_o     = (cmd_i.op == aec_pkg::OP_LOAD);
  assign rev_raddr_o  = rpos_q;
  assign echo_re_o    = (cmd_i.op == aec_pkg::OP_LOAD);
  assign echo_raddr_o = epos_q;

  always_comb begin
    if (!clr_done) begin
      rev_we_o     = (clr_q < CLW'(REVERB_DEPTH));
      rev_waddr_o  = clr_q[RAW-1:0];
      rev_wdata_o  = '0;
      echo_we_o    = (clr_q < CLW'(ECHO_DEPTH));
      echo_waddr_o = clr_q[EAW-1:0];
      echo_wdata_o = '0;
    end else begin
      rev_we_o     = (cmd_i.op == aec_pkg::OP_REV_WR);
      rev_waddr_o  = rpos_q;
      rev_wdata_o  = rev_wval;
      echo_we_o    = (cmd_i.op == aec_pkg::OP_ECHO);
      echo_waddr_o = epos_q;
      echo_wdata_o = s_q;
    end
  end

  assign status_o.clear_done = clr_done;
  assign status_o.no_input   = no_in_q;
  assign status_o.enables    = cfg_i.effect_enables;

  assign left_out_o  = lo_q;
  assign right_out_o = ro_q;

endmodule

[hw/rtl/audio_effects_chain.sv]
// Mono in, stereo out. Each transaction on the input side produces exactly one transaction
// on the output side: the sample is divided by the tracked peak level, then passes the
// enabled reverb, echo, gain and fade stages. Items are handled one at a time; most of the
// time per item is spent in the restoring divider, which retires one quotient bit per cycle.
// A silent item (no_input_i high) skips the divider and the effect stages. A finished result
// waits in the output register while the next item is taken. After reset both delay lines
// are cleared one entry per cycle, with the input stalled; register writes are accepted
// during that time.
module audio_effects_chain #(
  parameter int unsigned REVERB_DEPTH = 65536,
  parameter int unsigned ECHO_DEPTH   = 262144,
  parameter int unsigned BLOCK_FRAMES = 1024,
  parameter int unsigned FRAC_BITS    = 15
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic signed [15:0] sample_in_i,
  input  logic               no_input_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic signed [23:0] left_out_o,
  output logic signed [23:0] right_out_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned RAW = $clog2(REVERB_DEPTH);
  localparam int unsigned EAW = $clog2(ECHO_DEPTH);

  aec_pkg::cfg_t    cfg_q;
  aec_pkg::cmd_t    cmd;
  aec_pkg::status_t status;
  logic             wr_en;

  logic           rev_we, rev_re, echo_we, echo_re;
  logic [RAW-1:0] rev_waddr, rev_raddr;
  logic [EAW-1:0] echo_waddr, echo_raddr;
  logic [23:0]    rev_wdata, rev_rdata, echo_wdata, echo_rdata;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.effect_enables  <= 4'd0;
      cfg_q.fade_gain       <= 16'd0;
      cfg_q.clip_gain       <= 5'd10;
      cfg_q.reverb_length   <= 16'd44100;
      cfg_q.delay_length    <= 18'd132300;
      cfg_q.reverb_mix      <= 16'd8192;
      cfg_q.reverb_feedback <= 16'd16384;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        aec_pkg::REG_ENABLES:  cfg_q.effect_enables  <= pwdata[3:0];
        aec_pkg::REG_FADE:     cfg_q.fade_gain       <= pwdata[15:0];
        aec_pkg::REG_CLIP:     cfg_q.clip_gain       <= pwdata[4:0];
        aec_pkg::REG_REV_LEN:  cfg_q.reverb_length   <= pwdata[15:0];
        aec_pkg::REG_DLY_LEN:  cfg_q.delay_length    <= pwdata[17:0];
        aec_pkg::REG_MIX:      cfg_q.reverb_mix      <= pwdata[15:0];
        aec_pkg::REG_FEEDBACK: cfg_q.reverb_feedback <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      aec_pkg::REG_ENABLES:  prdata = 32'(cfg_q.effect_enables);
      aec_pkg::REG_FADE:     prdata = 32'(cfg_q.fade_gain);
      aec_pkg::REG_CLIP:     prdata = 32'(cfg_q.clip_gain);
      aec_pkg::REG_REV_LEN:  prdata = 32'(cfg_q.reverb_length);
      aec_pkg::REG_DLY_LEN:  prdata = 32'(cfg_q.delay_length);
      aec_pkg::REG_MIX:      prdata = 32'(cfg_q.reverb_mix);
      aec_pkg::REG_FEEDBACK: prdata = 32'(cfg_q.reverb_feedback);
      default:               prdata = '0;
    endcase
  end

  aec_ctrl #(
    .DIV_STEPS(16 + FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  aec_dp #(
    .REVERB_DEPTH(REVERB_DEPTH),
    .ECHO_DEPTH  (ECHO_DEPTH),
    .BLOCK_FRAMES(BLOCK_FRAMES),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .status_o    (status),
    .sample_in_i (sample_in_i),
    .no_input_i  (no_input_i),
    .left_out_o  (left_out_o),
    .right_out_o (right_out_o),
    .rev_we_o    (rev_we),
    .rev_waddr_o (rev_waddr),
    .rev_wdata_o (rev_wdata),
    .rev_re_o    (rev_re),
    .rev_raddr_o (rev_raddr),
    .rev_rdata_i (rev_rdata),
    .echo_we_o   (echo_we),
    .echo_waddr_o(echo_waddr),
    .echo_wdata_o(echo_wdata),
    .echo_re_o   (echo_re),
    .echo_raddr_o(echo_raddr),
    .echo_rdata_i(echo_rdata)
  );

  aec_ram #(
    .WIDTH(24),
    .DEPTH(REVERB_DEPTH)
  ) u_rev_ram (
    .clk_i  (clk_i),
    .we_i   (rev_we),
    .waddr_i(rev_waddr),
    .wdata_i(rev_wdata),
    .re_i   (rev_re),
    .raddr_i(rev_raddr),
    .rdata_o(rev_rdata)
  );

  aec_ram #(
    .WIDTH(24),
    .DEPTH(ECHO_DEPTH)
  ) u_echo_ram (
    .clk_i  (clk_i),
    .we_i   (echo_we),
    .waddr_i(echo_waddr),
    .wdata_i(echo_wdata),
    .re_i   (echo_re),
    .raddr_i(echo_raddr),
    .rdata_o(echo_rdata)
  );

endmodule
